// ===== rtl/fisp_pkg.sv =====
package fisp_pkg;

    localparam int POOL_DEPTH_DEF = 64;

    localparam int HANDLE_W    = 32;
    localparam int OFFSET_W    = 22;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int ACTION_W    = 2;
    localparam int POOL_SIZE_W = 7;
    localparam int RES_SIZE_W  = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [HANDLE_W-1:0] INVALID_HANDLE = 32'hFFFF_FFFF;

    localparam logic [ACTION_W-1:0] ACT_OBTAIN   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE_ALL = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_ACCESS   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_SIZE  = 1'b1;

    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 7'd64;
    localparam logic [RES_SIZE_W-1:0]  RES_SIZE_RST  = 16'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic [OFFSET_W-1:0] byte_offset;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  in_use_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

endpackage

// ===== rtl/fisp_ctrl.sv =====
module fisp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output fisp_pkg::cmd_t   cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // The request runs once the stack read is back and the output slot is free.
    assign s_ready     = (state_reg == S_IDLE);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.exec    = (state_reg == S_EXEC) && (!out_valid_reg || m_ready);
    assign m_valid     = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.capture) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd.exec) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/fisp_dp.sv =====
module fisp_dp #(
    parameter int POOL_DEPTH = fisp_pkg::POOL_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fisp_pkg::cmd_t                       cmd,
    input  fisp_pkg::req_t                       s_data,
    output fisp_pkg::rsp_t                       m_data,
    input  logic                                 cfg_wr_en,
    input  logic [fisp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fisp_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int HW = $clog2(POOL_DEPTH + 1);
    localparam int SW = (HW > fisp_pkg::POOL_SIZE_W) ? HW : fisp_pkg::POOL_SIZE_W;
    localparam int PW = fisp_pkg::OFFSET_W + fisp_pkg::RES_SIZE_W;

    logic [AW-1:0] mem [POOL_DEPTH];
    logic [AW-1:0] rd_data_reg;

    logic [HW-1:0] head_reg, head_next;
    logic [HW-1:0] wm_reg, wm_next;
    logic [fisp_pkg::POOL_SIZE_W-1:0] pool_size_reg;
    logic [fisp_pkg::RES_SIZE_W-1:0]  res_size_reg;

    fisp_pkg::req_t req_reg;
    fisp_pkg::rsp_t out_reg, out_next;

    logic [SW-1:0] pool_ext, depth_c, size_c, head_ext;
    logic [AW-1:0] popped;
    logic [AW-1:0] wr_addr;
    logic          mem_we;
    logic [PW-1:0] prod;

    // Entries at or above the high-water mark have not been written since
    // the last refill, so a pop there takes its own index, not the stored data.
    assign popped = (head_reg >= wm_reg) ? head_reg[AW-1:0] : rd_data_reg;

    always_comb begin
        pool_ext = SW'(pool_size_reg);
        depth_c  = SW'(POOL_DEPTH);
        size_c   = (pool_ext > depth_c) ? depth_c : pool_ext;
        head_ext = SW'(head_reg);
        prod     = PW'(req_reg.handle[fisp_pkg::OFFSET_W-1:0]) * PW'(res_size_reg);

        head_next = head_reg;
        wm_next   = wm_reg;
        mem_we    = 1'b0;
        wr_addr   = AW'(head_reg - HW'(1));

        out_next.result_handle = fisp_pkg::INVALID_HANDLE;
        out_next.byte_offset   = '0;
        out_next.status        = fisp_pkg::ST_OK;

        unique case (req_reg.action)
            fisp_pkg::ACT_OBTAIN: begin
                if (head_ext < size_c) begin
                    out_next.result_handle = fisp_pkg::HANDLE_W'(popped);
                    head_next = head_reg + HW'(1);
                    if (head_next > wm_reg) begin
                        wm_next = head_next;
                    end
                end else begin
                    out_next.status = fisp_pkg::ST_EXHAUSTED;
                end
            end
            fisp_pkg::ACT_RELEASE: begin
                if (head_reg == '0) begin
                    out_next.status = fisp_pkg::ST_UNDERFLOW;
                end else if (req_reg.handle >= fisp_pkg::HANDLE_W'(size_c)) begin
                    out_next.status = fisp_pkg::ST_INVALID;
                end else begin
                    head_next = head_reg - HW'(1);
                    mem_we    = 1'b1;
                end
            end
            fisp_pkg::ACT_FREE_ALL: begin
                head_next = '0;
                wm_next   = '0;
            end
            fisp_pkg::ACT_ACCESS: begin
                if (req_reg.handle == fisp_pkg::INVALID_HANDLE) begin
                    out_next.status = fisp_pkg::ST_INVALID;
                end else begin
                    out_next.byte_offset = prod[fisp_pkg::OFFSET_W-1:0];
                end
            end
            default: out_next.status = fisp_pkg::ST_OK;
        endcase

        out_next.in_use_count = fisp_pkg::COUNT_W'(head_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            wm_reg        <= '0;
            pool_size_reg <= fisp_pkg::POOL_SIZE_RST;
            res_size_reg  <= fisp_pkg::RES_SIZE_RST;
        end else begin
            if (cmd.exec) begin
                head_reg <= head_next;
                wm_reg   <= wm_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    fisp_pkg::CFG_POOL_SIZE:
                        pool_size_reg <= cfg_wr_data[fisp_pkg::POOL_SIZE_W-1:0];
                    fisp_pkg::CFG_RES_SIZE:
                        res_size_reg <= cfg_wr_data[fisp_pkg::RES_SIZE_W-1:0];
                    default: pool_size_reg <= pool_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    // Stack storage: one write port, one registered read at the head.
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[wr_addr] <= req_reg.handle[AW-1:0];
        end
        rd_data_reg <= mem[head_reg[AW-1:0]];
    end

    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_head_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= wm_reg)
        else $error("stack head above high-water mark");

    a_mark_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        wm_reg <= HW'(POOL_DEPTH))
        else $error("high-water mark beyond stack depth");

    a_free_all_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && req_reg.action == fisp_pkg::ACT_FREE_ALL)
        |=> (head_reg == '0 && wm_reg == '0 && out_reg.in_use_count == '0))
        else $error("free all did not empty the pool");

    a_no_write_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && mem_we) |-> (head_reg != '0))
        else $error("stack write with empty head");
`endif

endmodule

// ===== rtl/free_index_stack_pool_top.sv =====
// Fixed-size slot allocator built on a stack of free slot indices. Each input
// transaction carries an action (obtain, release, free all or access) and a
// handle, and produces exactly one result transaction with the handle handed
// out, the byte offset for an access (handle times resource_size, low 22 bits),
// a status code and the number of slots outstanding afterwards. Obtain pops
// the next free index or reports exhaustion with the all-ones handle; release
// pushes a handle back and flags a release with nothing outstanding or a
// handle at or beyond the active pool size, leaving the state untouched; free
// all empties the pool at once. Each item is accepted, with the free stack
// memory read at the head, and then executed: the registered read data and
// the offset multiplier feed the output register, which is loaded once it is
// free or being read. A new transaction is accepted while a result still
// waits in the output register, but not before the last one has executed.
// There is no clearing pass after reset or free all: a high-water mark tells
// which stack entries are read as their own index. pool_size (register 0) and
// resource_size (register 1) are written through the configuration port by
// the user only while the block is idle; the block does not enforce this.
module free_index_stack_pool_top #(
    parameter int POOL_DEPTH = fisp_pkg::POOL_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  fisp_pkg::req_t                     s_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output fisp_pkg::rsp_t                     m_data,

    input  logic                               cfg_wr_en,
    input  logic [fisp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fisp_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    fisp_pkg::cmd_t cmd;

    // The controller sequences each transaction and owns the result valid.
    fisp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the stack, head, configuration and result register.
    fisp_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule
